@@ rtl/stepper_half_step_packet_controller_core_macros.svh @@
// Assertion macros for the stepper half-step packet controller.
// Used by the top level only; needs no package.
`ifndef STEPPER_HALF_STEP_PACKET_CONTROLLER_CORE_MACROS_SVH
`define STEPPER_HALF_STEP_PACKET_CONTROLLER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SHPC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SHPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/shpc_pkg.sv @@
// Shared types, codes and constants of the stepper half-step packet controller.
// No dependencies.
package shpc_pkg;

  localparam int unsigned PACKET_LEN = 5;
  localparam int unsigned PHASES     = 8;
  localparam int unsigned CMD_DEPTH  = 2;
  localparam int unsigned RES_DEPTH  = 2;

  localparam logic [7:0] START_BYTE = 8'd255;
  localparam logic [7:0] FORCE_BYTE = 8'd255;

  localparam logic [7:0] CMD_RUN_CW   = 8'd1;
  localparam logic [7:0] CMD_RUN_CCW  = 8'd2;
  localparam logic [7:0] CMD_STEP_CW  = 8'd3;
  localparam logic [7:0] CMD_STEP_CCW = 8'd4;

  localparam logic [7:0] ESC_HIGH = 8'd1;
  localparam logic [7:0] ESC_LOW  = 8'd2;
  localparam logic [7:0] ESC_BOTH = 8'd3;

  localparam logic [1:0] MODE_STOP = 2'd0;
  localparam logic [1:0] MODE_CW   = 2'd1;
  localparam logic [1:0] MODE_CCW  = 2'd2;

  localparam logic [2:0] PHASE_RESET = 3'd7;
  localparam logic [6:0] ECHO_BASE   = 7'd97;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_DROP   = 2'd1,
    ACT_PACKET = 2'd2,
    ACT_TICK   = 2'd3
  } act_kind_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    act_kind_t   kind;
    logic [7:0]  cmd;
    logic [15:0] delay;
  } act_t;

  typedef struct packed {
    logic        step_taken;
    logic [2:0]  phase;
    logic [3:0]  coils;
    logic [6:0]  echo_char;
    logic [1:0]  run_mode;
    logic [15:0] step_delay;
    logic        packet_done;
    logic        packet_dropped;
  } out_item_t;

  function automatic logic [3:0] coil_pattern(input logic [2:0] ph);
    logic [3:0] pat;
    case (ph)
      3'd0: pat = 4'd1;
      3'd1: pat = 4'd3;
      3'd2: pat = 4'd2;
      3'd3: pat = 4'd6;
      3'd4: pat = 4'd4;
      3'd5: pat = 4'd12;
      3'd6: pat = 4'd8;
      3'd7: pat = 4'd9;
      default: pat = 4'd0;
    endcase
    return pat;
  endfunction

endpackage

@@ rtl/stepper_half_step_packet_controller_core.sv @@
// Stepper half-step packet controller: byte packets and ticks in, motor status out.
// Order: the edge that accepts an item writes the front queue; the back end moves it
// into the result queue once that queue has room, and empty drops when it is written.
// Throughput: one item per cycle; full rises only once the result side stalls.
// Reset (rst, synchronous, active high) empties both queues, clears the byte
// count and stops the motor with phase 7 and coils off.
module stepper_half_step_packet_controller_core #(
  parameter int unsigned CMD_DEPTH = shpc_pkg::CMD_DEPTH,
  parameter int unsigned RES_DEPTH = shpc_pkg::RES_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  shpc_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output shpc_pkg::out_item_t result
);

  `include "stepper_half_step_packet_controller_core_macros.svh"

  localparam int unsigned ACT_W = $bits(shpc_pkg::act_t);
  localparam int unsigned RES_W = $bits(shpc_pkg::out_item_t);

  logic                accept;
  shpc_pkg::act_t      act_in;
  shpc_pkg::act_t      act_out;
  logic                cmd_full;
  logic                cmd_empty;
  logic                act_pop;
  logic                res_full;
  logic                res_push;
  shpc_pkg::out_item_t res_in;

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  shpc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (in_item),
    .act    (act_in)
  );

  shpc_fifo #(
    .WIDTH (ACT_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (accept),
    .wdata (act_in),
    .full  (cmd_full),
    .rd    (act_pop),
    .rdata (act_out),
    .empty (cmd_empty)
  );

  shpc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .act_valid (!cmd_empty),
    .act       (act_out),
    .act_pop   (act_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  shpc_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_push),
    .wdata (res_in),
    .full  (res_full),
    .rd    (pop),
    .rdata (result),
    .empty (empty)
  );

  `SHPC_ASSERT_NEXT(a_accept_queued, clk, rst, accept, !cmd_empty, "accepted item not queued")
  `SHPC_ASSERT_SAME(a_step_coils, clk, rst, res_push && res_in.step_taken, res_in.coils != 4'd0, "step with coils off")
  `SHPC_ASSERT_SAME(a_done_xor_drop, clk, rst, res_push, !(res_in.packet_done && res_in.packet_dropped), "packet both done and dropped")

endmodule

@@ rtl/shpc_fifo.sv @@
// Small register FIFO used between front and back and at the result side.
// No package dependencies.
module shpc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == LAST) ? '0 : wptr + PW'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == LAST) ? '0 : rptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ rtl/shpc_front.sv @@
// Front end: gathers bytes into packets and classifies each item into an action.
// Depends on shpc_pkg.
module shpc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  shpc_pkg::in_item_t item,
  output shpc_pkg::act_t     act
);

  localparam logic [2:0] LAST_INDEX = 3'(shpc_pkg::PACKET_LEN - 1);

  logic [2:0] byte_count;
  logic [7:0] packet_bytes [4];
  logic [7:0] hi;
  logic [7:0] lo;

  // Apply the escape byte to the delay bytes.
  always_comb begin
    hi = packet_bytes[2];
    lo = packet_bytes[3];
    case (item.byte_value)
      shpc_pkg::ESC_BOTH: begin
        hi = shpc_pkg::FORCE_BYTE;
        lo = shpc_pkg::FORCE_BYTE;
      end
      shpc_pkg::ESC_HIGH: hi = shpc_pkg::FORCE_BYTE;
      shpc_pkg::ESC_LOW:  lo = shpc_pkg::FORCE_BYTE;
      default: ;
    endcase
  end

  always_comb begin
    act.kind  = shpc_pkg::ACT_NONE;
    act.cmd   = packet_bytes[1];
    act.delay = {hi, lo};
    if (item.operation == shpc_pkg::OP_TICK) begin
      act.kind = shpc_pkg::ACT_TICK;
    end else if (byte_count == LAST_INDEX) begin
      act.kind = (packet_bytes[0] == shpc_pkg::START_BYTE) ? shpc_pkg::ACT_PACKET
                                                          : shpc_pkg::ACT_DROP;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.operation == shpc_pkg::OP_BYTE && byte_count != LAST_INDEX) begin
      packet_bytes[byte_count[1:0]] <= item.byte_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (accept && item.operation == shpc_pkg::OP_BYTE) begin
      byte_count <= (byte_count == LAST_INDEX) ? '0 : byte_count + 3'd1;
    end
  end

endmodule

@@ rtl/shpc_back.sv @@
// Back end: runs the motor state (mode, delay, tick timer, phase) per action.
// Depends on shpc_pkg.
module shpc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                act_valid,
  input  shpc_pkg::act_t      act,
  output logic                act_pop,
  input  logic                res_full,
  output logic                res_push,
  output shpc_pkg::out_item_t res
);

  logic [2:0]  phase_reg;
  logic        energized;
  logic [1:0]  mode_reg;
  logic [15:0] delay_reg;
  logic [15:0] tick_count;

  logic [2:0]  phase_next;
  logic        energized_next;
  logic [1:0]  mode_next;
  logic [15:0] delay_next;
  logic [15:0] tick_next;
  logic        step;
  logic        step_cw;
  logic        done;
  logic        dropped;

  assign act_pop  = act_valid && !res_full;
  assign res_push = act_pop;

  always_comb begin
    mode_next  = mode_reg;
    delay_next = delay_reg;
    tick_next  = tick_count;
    step       = 1'b0;
    step_cw    = 1'b0;
    done       = 1'b0;
    dropped    = 1'b0;
    case (act.kind)
      shpc_pkg::ACT_DROP: dropped = 1'b1;
      shpc_pkg::ACT_PACKET: begin
        done      = 1'b1;
        tick_next = '0;
        if (act.cmd inside {shpc_pkg::CMD_RUN_CW, shpc_pkg::CMD_RUN_CCW}) begin
          mode_next  = (act.cmd == shpc_pkg::CMD_RUN_CW) ? shpc_pkg::MODE_CW
                                                         : shpc_pkg::MODE_CCW;
          delay_next = act.delay;
        end else begin
          mode_next = shpc_pkg::MODE_STOP;
          if (act.cmd inside {shpc_pkg::CMD_STEP_CW, shpc_pkg::CMD_STEP_CCW}) begin
            step    = 1'b1;
            step_cw = (act.cmd == shpc_pkg::CMD_STEP_CW);
          end
        end
      end
      shpc_pkg::ACT_TICK: begin
        if (mode_reg inside {shpc_pkg::MODE_CW, shpc_pkg::MODE_CCW}) begin
          if (tick_count >= delay_reg) begin
            tick_next = '0;
            step      = 1'b1;
            step_cw   = (mode_reg == shpc_pkg::MODE_CW);
          end else begin
            tick_next = tick_count + 16'd1;
          end
        end else begin
          tick_next = '0;
        end
      end
      default: ;
    endcase
    // Eight phases wrap naturally in three bits.
    if (step) begin
      phase_next     = step_cw ? phase_reg + 3'd1 : phase_reg - 3'd1;
      energized_next = 1'b1;
    end else begin
      phase_next     = phase_reg;
      energized_next = energized;
    end
  end

  always_comb begin
    res.step_taken     = step;
    res.phase          = phase_next;
    res.coils          = energized_next ? shpc_pkg::coil_pattern(phase_next) : 4'd0;
    res.echo_char      = shpc_pkg::ECHO_BASE + {4'd0, phase_next};
    res.run_mode       = mode_next;
    res.step_delay     = delay_next;
    res.packet_done    = done;
    res.packet_dropped = dropped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg  <= shpc_pkg::PHASE_RESET;
      energized  <= 1'b0;
      mode_reg   <= shpc_pkg::MODE_STOP;
      delay_reg  <= '0;
      tick_count <= '0;
    end else if (act_pop) begin
      phase_reg  <= phase_next;
      energized  <= energized_next;
      mode_reg   <= mode_next;
      delay_reg  <= delay_next;
      tick_count <= tick_next;
    end
  end

endmodule
